// ===== hdl/bitmap_block_allocator_unit_assert.svh =====
// Assertion macros of the bitmap block allocator RTL, used by bba_dp.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bba assertion failed");
// Checked at every edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bba assertion failed");
`else
`define BBA_ASSERT(lbl, prop)
`define BBA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hdl/bba_pkg.sv =====
// Types, constants and helpers of the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int unsigned NumBlocks      = 1024;
  localparam int unsigned ReservedBlocks = 32;
  localparam int unsigned MaxAlloc       = 64;
  localparam int unsigned ResEff         =
    (ReservedBlocks > NumBlocks) ? NumBlocks : ReservedBlocks;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BitW    = $clog2(WordW);
  localparam int unsigned NumRows = NumBlocks / WordW;
  localparam int unsigned RowW    = $clog2(NumRows);

  localparam int unsigned IdxW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned CountW = 7;

  localparam logic [CntW-1:0] CntReset = CntW'(NumBlocks - ResEff);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOB   = 2'd1,
    ST_DFREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARD,
    S_ALD,
    S_SCAN,
    S_OOB,
    S_FRD,
    S_FLD,
    S_FUPD
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [CountW-1:0] alloc_count;
    logic [IdxW-1:0]   free_block;
  } req_t;

  typedef struct packed {
    logic [IdxW-1:0] block_index;
    status_e         status;
    logic [CntW-1:0] free_count;
    logic            last;
  } res_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic rd_free;
    logic load;
    logic claim;
    logic wb;
    logic oob;
    logic free_upd;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic req_zero;
    logic has_zero;
    logic claim_last;
    logic last_row;
  } sts_t;

  function automatic logic [WordW-1:0] rst_row(input logic [RowW-1:0] row);
    logic [WordW-1:0] w;
    w = '0;
    for (int unsigned i = 0; i < WordW; i++) begin
      w[i] = ((int'(row) * WordW + i) < ResEff);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
// Controller state machine of the bitmap block allocator.
`default_nettype none
module bba_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t      cmd_o,
  output logic               busy_o
);
  import bba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (sts_i.req_free) begin
            state_d = S_FRD;
          end else if (!sts_i.req_zero) begin
            state_d = S_ARD;
          end
        end
      end
      S_ARD: state_d = S_ALD;
      S_ALD: state_d = S_SCAN;
      S_SCAN: begin
        if (sts_i.has_zero) begin
          if (sts_i.claim_last) begin
            state_d = S_IDLE;
          end
        end else if (sts_i.last_row) begin
          state_d = S_OOB;
        end else begin
          state_d = S_ARD;
        end
      end
      S_OOB:  state_d = S_IDLE;
      S_FRD:  state_d = S_FLD;
      S_FLD:  state_d = S_FUPD;
      S_FUPD: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.accept = start_i;
      S_ARD:  cmd_o.rd = 1'b1;
      S_ALD:  cmd_o.load = 1'b1;
      S_SCAN: begin
        cmd_o.claim = sts_i.has_zero;
        cmd_o.wb    = !sts_i.has_zero || sts_i.claim_last;
      end
      S_OOB:  cmd_o.oob = 1'b1;
      S_FRD: begin
        cmd_o.rd      = 1'b1;
        cmd_o.rd_free = 1'b1;
      end
      S_FLD:  cmd_o.load = 1'b1;
      S_FUPD: cmd_o.free_upd = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== hdl/bba_dp.sv =====
// Datapath: bitmap RAM, word scan, free counter and result register.
`default_nettype none
`include "bitmap_block_allocator_unit_assert.svh"
module bba_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bba_pkg::req_t req_i,
  input  wire bba_pkg::cmd_t cmd_i,
  output bba_pkg::sts_t      sts_o,
  output bba_pkg::res_t      res_o,
  output logic               strobe_o
);
  import bba_pkg::*;

  logic [CountW-1:0] want_q, want_d;
  logic [CountW-1:0] got_q, got_d;
  logic [IdxW-1:0]   fb_q, fb_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [RowW-1:0]   rd_row_q, rd_row_d;
  logic [WordW-1:0]  word_q, word_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [NumRows-1:0] vld_q, vld_d;
  res_t              res_q, res_d;
  logic              stb_q, stb_d;

  logic [RowW-1:0]  fb_row;
  logic [BitW-1:0]  fb_bit;
  logic [BitW-1:0]  zbit;
  logic [WordW-1:0] claim_word;
  logic [WordW-1:0] rdata;
  logic [RowW-1:0]  raddr;
  logic [RowW-1:0]  waddr;
  logic [WordW-1:0] wdata;
  logic             we;
  logic             free_ok;

  function automatic logic [BitW-1:0] low_zero(input logic [WordW-1:0] w);
    logic [BitW-1:0] idx;
    idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BitW'(i);
      end
    end
    return idx;
  endfunction

  assign fb_row     = RowW'(fb_q >> BitW);
  assign fb_bit     = fb_q[BitW-1:0];
  assign zbit       = low_zero(word_q);
  assign claim_word = word_q | (WordW'(1) << zbit);
  assign free_ok    = (32'(fb_q) < NumBlocks) && word_q[fb_bit];

  assign sts_o.req_free   = req_i.mode;
  assign sts_o.req_zero   = (req_i.alloc_count == '0);
  assign sts_o.has_zero   = !(&word_q);
  assign sts_o.claim_last = ((got_q + CountW'(1)) == want_q);
  assign sts_o.last_row   = (row_q == RowW'(NumRows - 1));

  assign raddr = cmd_i.rd_free ? fb_row : row_q;
  assign we    = cmd_i.wb || (cmd_i.free_upd && free_ok);
  assign waddr = cmd_i.free_upd ? fb_row : row_q;
  assign wdata = cmd_i.free_upd ? (word_q & ~(WordW'(1) << fb_bit))
               : (cmd_i.claim ? claim_word : word_q);

  bba_ram #(
    .Width(WordW),
    .Depth(NumRows)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    want_d   = want_q;
    got_d    = got_q;
    fb_d     = fb_q;
    row_d    = row_q;
    rd_row_d = rd_row_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    vld_d    = vld_q;
    res_d    = res_q;
    stb_d    = 1'b0;

    if (cmd_i.accept) begin
      want_d = (32'(req_i.alloc_count) > MaxAlloc) ? CountW'(MaxAlloc) : req_i.alloc_count;
      got_d  = '0;
      fb_d   = req_i.free_block;
      row_d  = '0;
    end
    if (cmd_i.rd) begin
      rd_row_d = raddr;
    end
    if (cmd_i.load) begin
      word_d = vld_q[rd_row_q] ? rdata : rst_row(rd_row_q);
    end
    if (cmd_i.claim) begin
      word_d = claim_word;
      got_d  = got_q + CountW'(1);
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CntW'(1);
      end
      stb_d             = 1'b1;
      res_d.block_index = IdxW'({row_q, zbit});
      res_d.status      = ST_OK;
      res_d.free_count  = cnt_d;
      res_d.last        = sts_o.claim_last;
    end
    if (cmd_i.wb && !sts_o.last_row) begin
      row_d = row_q + RowW'(1);
    end
    if (cmd_i.oob) begin
      stb_d             = 1'b1;
      res_d.block_index = '0;
      res_d.status      = ST_OOB;
      res_d.free_count  = cnt_q;
      res_d.last        = 1'b1;
    end
    if (cmd_i.free_upd) begin
      if (free_ok) begin
        cnt_d = cnt_q + CntW'(1);
      end
      stb_d             = 1'b1;
      res_d.block_index = fb_q;
      res_d.status      = free_ok ? ST_OK : ST_DFREE;
      res_d.free_count  = cnt_d;
      res_d.last        = 1'b1;
    end
    if (we) begin
      vld_d[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntReset;
      vld_q <= '0;
      stb_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= vld_d;
      stb_q <= stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q   <= want_d;
    got_q    <= got_d;
    fb_q     <= fb_d;
    row_q    <= row_d;
    rd_row_q <= rd_row_d;
    word_q   <= word_d;
    res_q    <= res_d;
  end

  assign res_o    = res_q;
  assign strobe_o = stb_q;

  `BBA_ASSERT(a_claim_has_zero, cmd_i.claim |-> !(&word_q))
  `BBA_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || (32'(cnt_q) <= NumBlocks))
  `BBA_ASSERT(a_oob_is_last, stb_q && (res_q.status == ST_OOB) |-> res_q.last)

endmodule
`default_nettype wire

// ===== hdl/bitmap_block_allocator_unit.sv =====
// First-fit bitmap block allocator, top level.
// Drive start while busy is low to hand over a transaction. An allocate
// scans the bitmap from block 0, one 32-bit word of the bitmap RAM at a
// time: each word visited is read, loaded and written back, and each
// claimed block gives one result; on the word that completes the request
// the write back shares the cycle of the final claim. Requests are capped
// at 64 blocks; a scan that runs off the end of the 32 words gives one
// out-of-blocks result. A free passes through read, load and update and
// gives one result. An allocate of zero blocks gives no result and leaves
// busy low. Results appear one per strobe cycle and must be taken as they
// come; the final result of a transaction has last set and is shown in the
// first cycle with busy low, so a new transaction may start in that cycle.
`default_nettype none
module bitmap_block_allocator_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire bba_pkg::req_t req_i,
  output bba_pkg::res_t      result_o,
  output logic               result_strobe_o
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  bba_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .res_o   (result_o),
    .strobe_o(result_strobe_o)
  );

endmodule
`default_nettype wire
